@@ rtl/slow_sample_window_detector_assert.svh @@
// Assertion helpers for the slow-sample window detector.
// Both expect clk and arst_n in scope.
`ifndef SLOW_SAMPLE_WINDOW_DETECTOR_ASSERT_SVH
`define SLOW_SAMPLE_WINDOW_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define SWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/swd_pkg.sv @@
`timescale 1ns / 1ps
package swd_pkg;

	localparam int SAMPLE_W = 32;
	localparam int RATIO_W  = 8;
	localparam int OUT_SUM_W = 38;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int OUT_DATA_W = 1 + OUT_SUM_W + 1;

	localparam logic [SAMPLE_W-1:0] MIN_SLOW_RST = 32'd500;
	localparam logic [RATIO_W-1:0]  RATIO_RST    = 8'd2;
	localparam logic [SAMPLE_W-1:0] AVG_CEIL_RST = 32'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SLOW = 2'd0,
		REG_RATIO    = 2'd1,
		REG_AVG_CEIL = 2'd2
	} cfg_reg_t;

	// fill status of one word as it travels down the pipe
	typedef struct packed {
		logic full_prev;  // ring was full before this word
		logic full_now;   // ring is full after this word
	} fill_flags_t;

endpackage

@@ rtl/slow_sample_window_detector.sv @@
// Path: an accepted word passes the stage 1 register, the swd_check product
//   stage and the output register. Throughput: one word per cycle unless m_axis
//   stalls; sum update and sample line shift both complete in the accept cycle.
// Reset (arst_n low, async): running sum, fill index and fill flag clear, the
//   three registers return to 500 / 2 / 1000; sample line contents stay undefined.
`timescale 1ns / 1ps
module slow_sample_window_detector #(
	parameter int WINDOW = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream: sample_time[31:0]
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [swd_pkg::SAMPLE_W-1:0]      s_axis_tdata,
	// result stream: slow_alarm[0], window_sum[38:1], window_full[39]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [swd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import swd_pkg::*;

`include "slow_sample_window_detector_assert.svh"

	// Sum of up to WINDOW 32-bit samples never wraps at this width.
	localparam int IDX_W = $clog2(WINDOW);
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	// ---------------- configuration ----------------
	logic [SAMPLE_W-1:0] min_slow_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [SAMPLE_W-1:0] avg_ceil_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_slow_q <= MIN_SLOW_RST;
			ratio_q    <= RATIO_RST;
			avg_ceil_q <= AVG_CEIL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_SLOW: min_slow_q <= cfg_data[SAMPLE_W-1:0];
				REG_RATIO:    ratio_q    <= cfg_data[RATIO_W-1:0];
				REG_AVG_CEIL: avg_ceil_q <= cfg_data[SAMPLE_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// ---------------- sample line ----------------
	// Cell 0 takes the new word; after WINDOW words the last cell holds the
	// oldest sample, which is the one leaving the window.
	logic s_acc;
	logic [SAMPLE_W-1:0] tap [WINDOW];

	assign s_acc = s_axis_tvalid && s_axis_tready;

	for (genvar i = 0; i < WINDOW; i++) begin : g_line
		if (i == 0) begin : g_head
			swd_cell u_cell (
				.clk   (clk),
				.shift (s_acc),
				.d     (s_axis_tdata),
				.q     (tap[i])
			);
		end else begin : g_body
			swd_cell u_cell (
				.clk   (clk),
				.shift (s_acc),
				.d     (tap[i-1]),
				.q     (tap[i])
			);
		end
	end

	// ---------------- running sum / fill tracking ----------------
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] idx_q;
	logic             filled_q;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W:0]   sum_upd;
	logic [SUM_W-1:0] sum_next;
	logic             wrap;

	// one extra bit: sum plus incoming sample may briefly exceed SUM_W
	assign sum_add  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(s_axis_tdata);
	assign sum_upd  = filled_q ? (sum_add - (SUM_W+1)'(tap[WINDOW-1])) : sum_add;
	assign sum_next = sum_upd[SUM_W-1:0];
	assign wrap     = (idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			idx_q    <= '0;
			filled_q <= 1'b0;
		end else if (s_acc) begin
			sum_q    <= sum_next;
			idx_q    <= wrap ? '0 : idx_q + 1'b1;
			filled_q <= filled_q || wrap;
		end
	end

	// ---------------- stage 1 ----------------
	logic                v_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SUM_W-1:0]    sum_s1;
	fill_flags_t         flags_s1;
	logic                ready_s2;

	assign s_axis_tready = !v_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_s1          <= s_axis_tdata;
			sum_s1             <= sum_next;
			flags_s1.full_prev <= filled_q;
			flags_s1.full_now  <= filled_q || wrap;
		end
	end

	// ---------------- alarm test and result register ----------------
	swd_check #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s1),
		.in_ready      (ready_s2),
		.in_flags      (flags_s1),
		.in_sample     (sample_s1),
		.in_sum        (sum_s1),
		.min_slow      (min_slow_q),
		.ratio         (ratio_q),
		.avg_ceil      (avg_ceil_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// ---------------- checks ----------------
	`SWD_ASSERT_NOW(a_alarm_needs_full, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[OUT_DATA_W-1], "alarm on a word before the window was full")
	`SWD_ASSERT_NEXT(a_fill_sticky, filled_q, filled_q, "fill flag dropped")
	`SWD_ASSERT_NEXT(a_fill_on_wrap, s_acc && wrap, filled_q && (idx_q == '0), "index wrap did not mark the window full")

endmodule

@@ rtl/swd_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sample line: takes the neighbor's sample on shift.
module swd_cell (
	input  logic                         clk,
	input  logic                         shift,
	input  logic [swd_pkg::SAMPLE_W-1:0] d,
	output logic [swd_pkg::SAMPLE_W-1:0] q
);
	import swd_pkg::*;

	logic [SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

@@ rtl/swd_check.sv @@
`timescale 1ns / 1ps
// Alarm test: products in the first stage, compare into the output register.
module swd_check #(
	parameter int WINDOW = 50,
	parameter int SUM_W  = 38
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  swd_pkg::fill_flags_t               in_flags,
	input  logic [swd_pkg::SAMPLE_W-1:0]       in_sample,
	input  logic [SUM_W-1:0]                   in_sum,
	input  logic [swd_pkg::SAMPLE_W-1:0]       min_slow,
	input  logic [swd_pkg::RATIO_W-1:0]        ratio,
	input  logic [swd_pkg::SAMPLE_W-1:0]       avg_ceil,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// slow_alarm, window_sum[37:0], window_full from bit 0 up
	output logic [swd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import swd_pkg::*;

	localparam int PROD_W = SUM_W + RATIO_W;

	logic                v_s2;
	logic [SUM_W-1:0]    scaled_s2;
	logic [PROD_W-1:0]   ratio_s2;
	logic [SUM_W-1:0]    ceil_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic                gtmin_s2;
	fill_flags_t         flags_s2;

	logic                out_valid_q;
	logic                alarm_q;
	logic [OUT_SUM_W-1:0] out_sum_q;
	logic                out_full_q;

	logic                out_free;
	logic                take_s2;
	logic                alarm;
	logic [63:0]         sum_wide;

	assign out_free = !out_valid_q || m_axis_tready;
	assign in_ready = !v_s2 || out_free;
	assign take_s2  = v_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			scaled_s2 <= SUM_W'(in_sample) * SUM_W'(WINDOW);
			ratio_s2  <= PROD_W'(ratio) * PROD_W'(in_sum);
			ceil_s2   <= SUM_W'(avg_ceil) * SUM_W'(WINDOW);
			sum_s2    <= in_sum;
			gtmin_s2  <= in_sample > min_slow;
			flags_s2  <= in_flags;
		end
	end

	assign alarm = flags_s2.full_prev && gtmin_s2 &&
		((PROD_W'(scaled_s2) > ratio_s2) || (sum_s2 > ceil_s2));
	assign sum_wide = 64'(sum_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			alarm_q    <= alarm;
			out_sum_q  <= sum_wide[OUT_SUM_W-1:0];
			out_full_q <= flags_s2.full_now;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_full_q, out_sum_q, alarm_q};

endmodule
